// ===== hdl/fpc_pkg.sv =====
// Shared types, constants and sine table for the first-person camera pose block.
package fpc_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_SHIFT      = 16 - SINE_TABLE_BITS;
    localparam int SINE_HALF       = (1 << SINE_SHIFT) >> 1;
    localparam int QUARTER_STEPS   = 1 << (SINE_TABLE_BITS - 2);
    localparam int QIDX_W          = SINE_TABLE_BITS - 1;
    localparam int QUARTER_TURN    = 16384;

    localparam longint K_A = 102944;
    localparam longint K_B = 42048;
    localparam longint K_C = 4640;

    localparam logic [15:0] SENS_RESET = 16'd46603;
    localparam logic [14:0] PLIM_RESET = 15'd15838;

    typedef enum logic [1:0] {
        REG_SENS = 2'd0,
        REG_PLIM = 2'd1,
        REG_FREE = 2'd2
    } reg_index_t;

    typedef enum logic {
        OP_UPDATE   = 1'b0,
        OP_TELEPORT = 1'b1
    } op_t;

    typedef struct packed {
        logic               action;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic signed [31:0] front_dist;
        logic signed [31:0] right_dist;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [15:0] look_x;
        logic signed [15:0] look_y;
        logic signed [15:0] look_z;
    } out_t;

    typedef struct packed {
        op_t                op;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic signed [31:0] front_dist;
        logic signed [31:0] right_dist;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_z;
    } cmd_t;

    typedef struct packed {
        logic [15:0] sensitivity;
        logic [14:0] pitch_limit;
        logic        free_mode;
    } cfg_t;

    typedef logic [14:0] qsine_t [0:QUARTER_STEPS];

    function automatic qsine_t build_qsine();
        qsine_t tab;
        longint x, x2, t, u, y, q;
        for (int k = 0; k <= QUARTER_STEPS; k++) begin
            x  = longint'(k << SINE_SHIFT) << 2;
            x2 = (x * x) >> 16;
            t  = K_B - ((x2 * K_C) >> 16);
            u  = K_A - ((x2 * t) >> 16);
            y  = (x * u) >> 16;
            q  = (y + 2) >> 2;
            if (q > QUARTER_TURN) q = QUARTER_TURN;
            tab[k] = 15'(q);
        end
        return tab;
    endfunction

    localparam qsine_t QSINE = build_qsine();

    // Round to the nearest table step, fold into a quarter wave, restore sign.
    function automatic logic signed [15:0] sine_lookup(logic [15:0] angle);
        logic [16:0]                  rnd;
        logic [SINE_TABLE_BITS-1:0]   stp;
        logic [SINE_TABLE_BITS-3:0]   k;
        logic [QIDX_W-1:0]            idx;
        logic [15:0]                  v;
        rnd = {1'b0, angle} + 17'(SINE_HALF);
        stp = rnd[SINE_SHIFT +: SINE_TABLE_BITS];
        k   = stp[SINE_TABLE_BITS-3:0];
        if (stp[SINE_TABLE_BITS-2]) begin
            idx = QIDX_W'(QUARTER_STEPS) - {1'b0, k};
        end else begin
            idx = {1'b0, k};
        end
        v = {1'b0, QSINE[idx]};
        return stp[SINE_TABLE_BITS-1] ? -$signed(v) : $signed(v);
    endfunction

endpackage

// ===== hdl/fpc_front.sv =====
// Front end: accepts input transactions, classifies them and queues them.
module fpc_front
    import fpc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic head_valid,
    input  logic head_pop,
    output cmd_t head_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    cmd_t       cmd_in;

    always_comb begin
        cmd_in.op         = s_data.action ? OP_TELEPORT : OP_UPDATE;
        cmd_in.delta_x    = s_data.delta_x;
        cmd_in.delta_y    = s_data.delta_y;
        cmd_in.front_dist = s_data.front_dist;
        cmd_in.right_dist = s_data.right_dist;
        cmd_in.new_x      = s_data.new_x;
        cmd_in.new_y      = s_data.new_y;
        cmd_in.new_z      = s_data.new_z;
    end

    assign s_ready    = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign push       = s_valid && s_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = head_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, head_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        head_pop |-> head_valid) else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3) else $error("queue count out of range");
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2 && !head_pop) |=> (count_reg == 2'd2))
        else $error("full queue lost an entry");
`endif

endmodule

// ===== hdl/fpc_back.sv =====
// Back end: sequencer with one shared multiplier that updates the pose.
module fpc_back
    import fpc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic head_valid,
    output logic head_pop,
    input  cmd_t head_cmd,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    typedef enum logic [14:0] {
        ST_IDLE = 15'b000000000000001,
        ST_SX   = 15'b000000000000010,
        ST_SY   = 15'b000000000000100,
        ST_PC   = 15'b000000000001000,
        ST_LK   = 15'b000000000010000,
        ST_FSP  = 15'b000000000100000,
        ST_FCP  = 15'b000000001000000,
        ST_LH   = 15'b000000010000000,
        ST_LSY  = 15'b000000100000000,
        ST_LCY  = 15'b000001000000000,
        ST_RCY  = 15'b000010000000000,
        ST_RSY  = 15'b000100000000000,
        ST_VSY  = 15'b001000000000000,
        ST_VCY  = 15'b010000000000000,
        ST_DONE = 15'b100000000000000
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic        [15:0] yaw_reg, yaw_next;
    logic signed [15:0] pitch_reg, pitch_next;
    logic signed [31:0] px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic signed [15:0] sp_reg, sp_next, cp_reg, cp_next;
    logic signed [15:0] sy_reg, sy_next, cy_reg, cy_next;
    logic signed [31:0] l_reg, l_next;
    logic signed [15:0] lx_reg, lx_next;
    logic signed [48:0] p_reg;
    logic signed [31:0] mul_a;
    logic signed [16:0] mul_b;
    logic               mv_reg, mv_next;
    out_t               md_reg, md_next;

    logic signed [48:0] p_rnd14, p_rnd8;
    logic signed [34:0] rq;
    logic signed [25:0] sd;
    logic signed [26:0] p_new, lim_s;
    logic        [14:0] lim;
    logic               out_free;

    function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                   logic signed [34:0] d);
        logic signed [35:0] s;
        s = 36'(a) + 36'(d);
        if (s > 36'sd2147483647) return 32'sh7FFFFFFF;
        if (s < -36'sd2147483648) return 32'sh80000000;
        return s[31:0];
    endfunction

    assign p_rnd14  = p_reg + 49'sd8192;
    assign p_rnd8   = p_reg + 49'sd128;
    assign rq       = p_rnd14[48:14];
    assign sd       = p_rnd8[33:8];
    assign lim      = (cfg.pitch_limit > 15'd16384) ? 15'd16384 : cfg.pitch_limit;
    assign lim_s    = $signed({12'd0, lim});
    assign p_new    = 27'(pitch_reg) - 27'(sd);
    assign out_free = !mv_reg || m_ready;

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = 32'(cp_reg);
        mul_b = 17'(cy_reg);
        unique case (state_reg)
            ST_SX:   begin mul_a = 32'(cmd_reg.delta_x); mul_b = $signed({1'b0, cfg.sensitivity}); end
            ST_SY:   begin mul_a = 32'(cmd_reg.delta_y); mul_b = $signed({1'b0, cfg.sensitivity}); end
            ST_FSP:  begin mul_a = cmd_reg.front_dist; mul_b = 17'(sp_reg); end
            ST_FCP:  begin mul_a = cmd_reg.front_dist; mul_b = 17'(cp_reg); end
            ST_LSY:  begin mul_a = l_reg; mul_b = 17'(sy_reg); end
            ST_LCY:  begin mul_a = l_reg; mul_b = 17'(cy_reg); end
            ST_RCY:  begin mul_a = cmd_reg.right_dist; mul_b = 17'(cy_reg); end
            ST_RSY:  begin mul_a = cmd_reg.right_dist; mul_b = 17'(sy_reg); end
            ST_VSY:  begin mul_a = 32'(cp_reg); mul_b = 17'(sy_reg); end
            default: begin mul_a = 32'(cp_reg); mul_b = 17'(cy_reg); end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        yaw_next   = yaw_reg;
        pitch_next = pitch_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        pz_next    = pz_reg;
        sp_next    = sp_reg;
        cp_next    = cp_reg;
        sy_next    = sy_reg;
        cy_next    = cy_reg;
        l_next     = l_reg;
        lx_next    = lx_reg;
        mv_next    = mv_reg && !m_ready;
        md_next    = md_reg;
        head_pop   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (head_valid) begin
                    head_pop = 1'b1;
                    cmd_next = head_cmd;
                    if (head_cmd.op == OP_TELEPORT) begin
                        px_next    = head_cmd.new_x;
                        py_next    = head_cmd.new_y;
                        pz_next    = head_cmd.new_z;
                        state_next = ST_LK;
                    end else begin
                        state_next = ST_SX;
                    end
                end
            end
            ST_SX:  state_next = ST_SY;
            ST_SY: begin
                yaw_next   = yaw_reg + sd[15:0];
                state_next = ST_PC;
            end
            ST_PC: begin
                if (p_new > lim_s) pitch_next = lim_s[15:0];
                else if (p_new < -lim_s) pitch_next = -$signed(lim_s[15:0]);
                else pitch_next = p_new[15:0];
                state_next = ST_LK;
            end
            ST_LK: begin
                sp_next    = sine_lookup(pitch_reg);
                cp_next    = sine_lookup(pitch_reg + 16'(QUARTER_TURN));
                sy_next    = sine_lookup(yaw_reg);
                cy_next    = sine_lookup(yaw_reg + 16'(QUARTER_TURN));
                state_next = (cmd_reg.op == OP_TELEPORT) ? ST_VSY : ST_FSP;
            end
            ST_FSP: state_next = ST_FCP;
            ST_FCP: begin
                if (cfg.free_mode) py_next = sat_add(py_reg, rq);
                state_next = ST_LH;
            end
            ST_LH: begin
                l_next     = rq[31:0];
                state_next = ST_LSY;
            end
            ST_LSY: state_next = ST_LCY;
            ST_LCY: begin
                px_next    = sat_add(px_reg, rq);
                state_next = ST_RCY;
            end
            ST_RCY: begin
                pz_next    = sat_add(pz_reg, -rq);
                state_next = ST_RSY;
            end
            ST_RSY: begin
                px_next    = sat_add(px_reg, rq);
                state_next = ST_VSY;
            end
            ST_VSY: begin
                // strafe z lands here only on an update
                if (cmd_reg.op == OP_UPDATE) pz_next = sat_add(pz_reg, rq);
                state_next = ST_VCY;
            end
            ST_VCY: begin
                lx_next    = rq[15:0];
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    mv_next        = 1'b1;
                    md_next.out_x  = px_reg;
                    md_next.out_y  = py_reg;
                    md_next.out_z  = pz_reg;
                    md_next.look_x = lx_reg;
                    md_next.look_y = sp_reg;
                    md_next.look_z = -rq[15:0];
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
            yaw_reg   <= '0;
            pitch_reg <= '0;
            px_reg    <= '0;
            py_reg    <= '0;
            pz_reg    <= '0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            yaw_reg   <= yaw_next;
            pitch_reg <= pitch_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            pz_reg    <= pz_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        sp_reg  <= sp_next;
        cp_reg  <= cp_next;
        sy_reg  <= sy_next;
        cy_reg  <= cy_next;
        l_reg   <= l_next;
        lx_reg  <= lx_next;
        md_reg  <= md_next;
        p_reg   <= mul_a * mul_b;
    end

    assign m_valid = mv_reg;
    assign m_data  = md_reg;

`ifndef SYNTHESIS
    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pitch_reg <= 16'sd16384) && (pitch_reg >= -16'sd16384))
        else $error("pitch beyond quarter turn");
    a_done_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> m_valid)
        else $error("finished item not presented");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        head_pop |-> (state_reg == ST_IDLE))
        else $error("queue popped while busy");
`endif

endmodule

// ===== hdl/first_person_camera_pose.sv =====
// Top level of the first-person camera pose tracker.
// Usage:
//   s_valid/s_ready/s_data carry one input transaction: an update (mouse
//   deltas plus forward and strafe distances) or a teleport (new position).
//   m_valid/m_ready/m_data return one transaction per input: position and
//   unit look vector after the item.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write sensitivity (0), pitch
//   limit (1) and free mode (2); other indexes are dropped. Write only while
//   the block is idle. cfg_ready is always high.
// Sequence:
//   An update steps through SX, SY, PC, LK, FSP, FCP, LH, LSY, LCY, RCY,
//   RSY, VSY, VCY and DONE after acceptance, a teleport through LK, VSY,
//   VCY and DONE; the single shared 32x17 multiplier is stepped through ten
//   products. One item is worked on at a time.
//   A two-entry queue in front takes new items while the back end works.
// Reset: aresetn (synchronous, low) clears angles and position to zero,
//   loads register defaults and empties the queue and output stage.
// Stall: a result held on m_data waits for m_ready; the back end keeps
//   working on the next item and holds only when it must deliver.
module first_person_camera_pose
    import fpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic head_valid, head_pop;
    cmd_t head_cmd;

    assign cfg_ready = 1'b1;

    // Decode configuration writes; unknown indexes leave registers alone
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_SENS: cfg_next.sensitivity = cfg_data;
                REG_PLIM: cfg_next.pitch_limit = cfg_data[14:0];
                REG_FREE: cfg_next.free_mode   = cfg_data[0];
                default:  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sensitivity <= SENS_RESET;
            cfg_reg.pitch_limit <= PLIM_RESET;
            cfg_reg.free_mode   <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accept and classify
    fpc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head_cmd   (head_cmd)
    );

    // Back: carry out the item and hold the result
    fpc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head_cmd   (head_cmd),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== tb/first_person_camera_pose_tb.sv =====
// Self-checking testbench for the first-person camera pose tracker.
`timescale 1ns / 100ps

class pose_scoreboard;
    fpc_pkg::out_t pending[$];
    int            errors;

    // Camera state and register copy used for prediction.
    logic [15:0]        sens;
    logic [14:0]        plim;
    logic               free;
    logic [15:0]        yaw;
    logic signed [15:0] pitch;
    logic signed [31:0] px, py, pz;

    function new();
        errors = 0;
        sens   = 16'd46603;
        plim   = 15'd15838;
        free   = 1'b1;
        yaw    = '0;
        pitch  = '0;
        px     = '0;
        py     = '0;
        pz     = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
        case (idx)
            fpc_pkg::REG_SENS: sens = data;
            fpc_pkg::REG_PLIM: plim = data[14:0];
            fpc_pkg::REG_FREE: free = data[0];
            default: ;
        endcase
    endfunction

    function longint floor_div(longint v, int n);
        return v >>> n;
    endfunction

    function longint quarter_wave(longint r);
        longint x, x2, t, u, y, q;
        x  = r << 2;
        x2 = (x * x) >> 16;
        t  = 42048 - ((x2 * 4640) >> 16);
        u  = 102944 - ((x2 * t) >> 16);
        y  = (x * u) >> 16;
        q  = (y + 2) >> 2;
        if (q > 16384) q = 16384;
        return q;
    endfunction

    function longint sine_of(logic [15:0] angle);
        logic [15:0] a;
        logic [1:0]  quad;
        longint      r, v;
        a    = 16'((({16'd0, angle} + 32'd32) >> 6) << 6);
        quad = a[15:14];
        r    = a[13:0];
        v    = quad[0] ? quarter_wave(16384 - r) : quarter_wave(r);
        return quad[1] ? -v : v;
    endfunction

    function longint cosine_of(logic [15:0] angle);
        return sine_of(angle + 16'd16384);
    endfunction

    function longint mul_q14(longint a, longint b);
        return floor_div(a * b + 8192, 14);
    endfunction

    function logic signed [31:0] sat(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return 32'(v);
    endfunction

    function longint scaled(logic signed [15:0] d);
        return floor_div(longint'(d) * longint'(sens) + 128, 8);
    endfunction

    // Advance the camera for one accepted input and queue its result.
    function void note_input(fpc_pkg::in_t item);
        fpc_pkg::out_t res;
        longint        lim, p, sp, cp, sy, cy, l;
        if (item.action == fpc_pkg::OP_TELEPORT) begin
            px = item.new_x;
            py = item.new_y;
            pz = item.new_z;
        end else begin
            lim = (plim > 15'd16384) ? 16384 : longint'(plim);
            yaw = 16'(longint'(yaw) + scaled(item.delta_x));
            p   = longint'(pitch) - scaled(item.delta_y);
            if (p > lim) p = lim;
            else if (p < -lim) p = -lim;
            pitch = 16'(p);
            sp = sine_of(pitch);
            cp = cosine_of(pitch);
            sy = sine_of(yaw);
            cy = cosine_of(yaw);
            if (free) py = sat(longint'(py) + mul_q14(item.front_dist, sp));
            l  = mul_q14(item.front_dist, cp);
            px = sat(longint'(px) + mul_q14(l, sy));
            pz = sat(longint'(pz) - mul_q14(l, cy));
            px = sat(longint'(px) + mul_q14(item.right_dist, cy));
            pz = sat(longint'(pz) + mul_q14(item.right_dist, sy));
        end
        sp = sine_of(pitch);
        cp = cosine_of(pitch);
        sy = sine_of(yaw);
        cy = cosine_of(yaw);
        res.out_x  = px;
        res.out_y  = py;
        res.out_z  = pz;
        res.look_x = 16'(mul_q14(cp, sy));
        res.look_y = 16'(sp);
        res.look_z = 16'(-mul_q14(cp, cy));
        pending.push_back(res);
    endfunction

    task report(string what, longint got, longint want);
        $display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    task check_result(fpc_pkg::out_t got);
        fpc_pkg::out_t want;
        if (pending.size() == 0) begin
            report("unexpected transaction", 0, 0);
            return;
        end
        want = pending.pop_front();
        if (got.out_x !== want.out_x) report("out_x", got.out_x, want.out_x);
        if (got.out_y !== want.out_y) report("out_y", got.out_y, want.out_y);
        if (got.out_z !== want.out_z) report("out_z", got.out_z, want.out_z);
        if (got.look_x !== want.look_x) report("look_x", got.look_x, want.look_x);
        if (got.look_y !== want.look_y) report("look_y", got.look_y, want.look_y);
        if (got.look_z !== want.look_z) report("look_z", got.look_z, want.look_z);
    endtask
endclass

module first_person_camera_pose_tb;
    import fpc_pkg::*;

    localparam int          DRAIN_CYCLES = 40;
    localparam logic [1:0]  REG_SPARE    = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_t         s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_t        m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    pose_scoreboard pose_sb = new();

    // Receiver controls: random stalls, a forced long hold-off, a calm tail.
    bit rx_hold_req = 1'b0;
    bit calm        = 1'b0;

    always #4 aclk = ~aclk;

    first_person_camera_pose dut (.*);

    // Check every result transaction as it is taken.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) pose_sb.check_result(m_data);
    end

    // Result side readiness: random stall bursts, or one long hold when asked.
    initial begin : receiver
        int n;
        @(posedge aresetn);
        forever begin
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                rx_hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 18);
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge aclk);
            end
        end
    end

    // Offer one transaction and hold it until accepted; valid stays up for
    // a back-to-back follower and drops only when the sender idles.
    task send_item(in_t item);
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pose_sb.note_input(item);
    endtask

    task idle_gap();
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            n = $urandom_range(1, 18);
            repeat (n) @(posedge aclk);
        end
    endtask

    // Wait for every expected result, then let the back end settle.
    task drain();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (pose_sb.pending.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task write_cfg(logic [1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        pose_sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function in_t update_item(int dx, int dy, int fd, int rd);
        in_t it;
        it            = '0;
        it.action     = OP_UPDATE;
        it.delta_x    = 16'(dx);
        it.delta_y    = 16'(dy);
        it.front_dist = fd;
        it.right_dist = rd;
        it.new_x      = $urandom;
        it.new_y      = $urandom;
        it.new_z      = $urandom;
        return it;
    endfunction

    function in_t teleport_item(int x, int y, int z);
        in_t it;
        it            = '0;
        it.action     = OP_TELEPORT;
        it.delta_x    = 16'($urandom);
        it.delta_y    = 16'($urandom);
        it.front_dist = $urandom;
        it.right_dist = $urandom;
        it.new_x      = x;
        it.new_y      = y;
        it.new_z      = z;
        return it;
    endfunction

    function in_t random_item();
        int kind;
        int fd, rd;
        kind = $urandom_range(0, 9);
        if (kind == 0) return teleport_item($urandom, $urandom, $urandom);
        if (kind == 1) return teleport_item($urandom_range(0, 2000000) - 1000000,
                                            $urandom_range(0, 2000000) - 1000000,
                                            $urandom_range(0, 2000000) - 1000000);
        // Mostly modest moves so saturation stays occasional.
        fd = (kind == 2) ? int'($urandom) : $urandom_range(0, 1 << 21) - (1 << 20);
        rd = (kind == 3) ? int'($urandom) : $urandom_range(0, 1 << 21) - (1 << 20);
        if (kind == 4) return update_item($urandom, $urandom, fd, rd);
        return update_item($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
                           fd, rd);
    endfunction

    initial begin : stimulus
        int phase;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, both operations and the listed corners.
        send_item(update_item(0, 0, 0, 0));
        send_item(update_item(32767, 0, 32'sh00010000, 0));
        send_item(update_item(-32768, 0, 0, 32'sh00010000));
        send_item(update_item(300, 0, 0, 0));          // yaw wraps
        send_item(update_item(0, -32768, 32'sh7FFFFFFF, 0)); // pitch clamps up
        send_item(update_item(0, 32767, 32'sh80000000, 0));  // pitch clamps down
        send_item(teleport_item(32'sh7FFFFFF0, 32'sh7FFFFFF0, 32'sh80000010));
        send_item(update_item(0, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF)); // saturate
        send_item(update_item(0, 0, 32'sh80000000, 32'sh80000000));
        send_item(teleport_item(32'sh80000000, 32'sh7FFFFFFF, 0));
        send_item(update_item(-1, 1, -1, -1));
        send_item(teleport_item(0, 0, 0));
        drain();
        write_cfg(REG_PLIM, 16'd2000);              // limit lowered below pitch
        send_item(teleport_item(5, 6, 7));          // pitch stays beyond limit
        send_item(update_item(0, 0, 0, 0));         // now clamped
        drain();
        write_cfg(REG_PLIM, 16'h7FFF);              // above a quarter turn
        write_cfg(REG_FREE, 16'hFFFE);              // bit 0 clear: height fixed
        write_cfg(REG_SENS, 16'hFFFF);
        write_cfg(REG_SPARE, 16'h1234);             // unused index dropped
        send_item(update_item(32767, -32768, 32'sh00400000, 0));
        send_item(update_item(-32768, 32767, 32'sh00400000, 32'sh00400000));
        drain();

        // Random phases, each with its own register setting.
        for (phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0: begin write_cfg(REG_SENS, 16'd0); write_cfg(REG_PLIM, 16'd0);
                         write_cfg(REG_FREE, 16'd1); end
                1: begin write_cfg(REG_SENS, 16'd46603); write_cfg(REG_PLIM, 16'd16384); end
                2: begin write_cfg(REG_SENS, 16'($urandom));
                         write_cfg(REG_PLIM, 16'($urandom));
                         write_cfg(REG_FREE, 16'd0); end
                3: begin write_cfg(REG_SENS, 16'd256); write_cfg(REG_PLIM, 16'd15838);
                         write_cfg(REG_FREE, 16'd1); end
                4: begin write_cfg(REG_SENS, 16'($urandom_range(0, 65535)));
                         write_cfg(REG_PLIM, 16'($urandom_range(0, 16384))); end
                default: begin write_cfg(REG_SENS, 16'd46603);
                         write_cfg(REG_FREE, 16'd1); calm = 1'b1; end
            endcase
            // Hold the receiver off while offering items so the queue fills.
            if (phase == 1) rx_hold_req = 1'b1;
            repeat (80) begin
                send_item(random_item());
                idle_gap();
            end
            // Pause until every result is back before resuming.
            if (phase == 3) drain();
        end
        drain();

        if (pose_sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
